// ===== rtl/lsp_pkg.sv =====
// Shared types and constants for the lottery scheduler pick block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsp_pkg;

  localparam int DEFAULT_MAX_TASKS = 16;

  localparam int SLOT_W    = 4;
  localparam int RUNTIME_W = 16;
  localparam int TICKETS_W = 10;
  localparam int TICKET_W  = 14;
  localparam int QUANTUM_W = 16;
  localparam int TCOUNT_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam int            TICKETS_MAX = 1023;
  localparam logic [15:0]   QUANTUM_RST = 16'd1;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [SLOT_W-1:0]    task_slot;
    logic [RUNTIME_W-1:0] load_runtime;
    logic [TICKETS_W-1:0] load_tickets;
    logic [TICKET_W-1:0]  drawn_ticket;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   chosen_task;
    logic                task_retired;
    logic                all_done;
    logic [TICKET_W-1:0] ticket_total;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic ld_read;
    logic ld_write;
    logic walk_read;
    logic walk_step;
    logic upd_write;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_end;
    logic hit;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/lsp_ctrl.sv =====
// Sequencer for the lottery scheduler pick: load and draw flows.
// Depends on lsp_pkg; drives lsp_dp through cmd_t, watches status_t.
`default_nettype none

module lsp_ctrl import lsp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    start_op,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy,
  output logic         done
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LD_RD = 7'b0000010,
    S_LD_WR = 7'b0000100,
    S_WK_RD = 7'b0001000,
    S_WK_EV = 7'b0010000,
    S_UPD   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = (start_op == OP_DRAW) ? S_WK_RD : S_LD_RD;
        end
      end
      S_LD_RD: begin
        cmd.ld_read = 1'b1;
        state_next  = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.ld_write = 1'b1;
        state_next   = S_RESP;
      end
      S_WK_RD: begin
        if (status.walk_end) begin
          state_next = S_RESP;
        end else begin
          cmd.walk_read = 1'b1;
          state_next    = S_WK_EV;
        end
      end
      S_WK_EV: begin
        if (status.hit) begin
          state_next = S_UPD;
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = S_WK_RD;
        end
      end
      S_UPD: begin
        cmd.upd_write = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

endmodule

`default_nettype wire

// ===== rtl/lsp_dp.sv =====
// Datapath: task table memories, valid bits, ticket walk, live total, config.
// Depends on lsp_pkg; sequenced by lsp_ctrl.
`default_nettype none

module lsp_dp import lsp_pkg::*; #(
  parameter int MAX_TASKS = DEFAULT_MAX_TASKS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire req_t                 req,
  input  wire cmd_t                 cmd,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  output status_t                   status,
  output rsp_t                      result
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int TW = $clog2(MAX_TASKS * TICKETS_MAX + 1);

  // configuration
  logic [QUANTUM_W-1:0] quantum;
  logic [TCOUNT_W-1:0]  task_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum    <= QUANTUM_RST;
      task_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUANTUM:    quantum    <= cfg_data[QUANTUM_W-1:0];
        CFG_TASK_COUNT: task_count <= cfg_data[TCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  req_t req_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= req;
    end
  end

  // task table
  logic [RUNTIME_W-1:0] mem_rt [MAX_TASKS];
  logic [TICKETS_W-1:0] mem_tk [MAX_TASKS];
  logic [MAX_TASKS-1:0] valid;

  logic [RUNTIME_W-1:0] rd_rt;
  logic [TICKETS_W-1:0] rd_tk;
  logic                 rd_vld;

  logic [CW-1:0] idx;
  logic [CW-1:0] limit;
  logic [TW-1:0] sum;
  logic [TW-1:0] live_total;

  logic          found_r;
  logic          retired_r;
  logic [SLOT_W-1:0] chosen_r;

  logic [AW-1:0] ld_addr;
  logic [AW-1:0] wk_addr;
  logic [AW-1:0] rd_addr;
  logic          slot_ok;

  assign ld_addr = AW'(req_r.task_slot);
  assign wk_addr = AW'(idx);
  assign rd_addr = cmd.ld_read ? ld_addr : wk_addr;
  assign slot_ok = (32'(req_r.task_slot) < MAX_TASKS);

  // entries never written read as zero
  logic [RUNTIME_W-1:0] eff_rt;
  logic [TICKETS_W-1:0] eff_tk;
  assign eff_rt = rd_vld ? rd_rt : '0;
  assign eff_tk = rd_vld ? rd_tk : '0;

  logic [TICKETS_W-1:0] ld_tk;
  logic [RUNTIME_W-1:0] new_rt;
  logic [TW-1:0]        sum_next;

  // zero runtime load carries no tickets
  assign ld_tk    = (req_r.load_runtime == '0) ? '0 : req_r.load_tickets;
  assign new_rt   = (eff_rt > quantum) ? (eff_rt - quantum) : '0;
  assign sum_next = sum + TW'(eff_tk);

  assign status.walk_end = (idx == limit);
  assign status.hit      = (32'(req_r.drawn_ticket) <= 32'(sum_next)) && (eff_rt != '0);

  always_ff @(posedge clk) begin
    if (cmd.ld_read || cmd.walk_read) begin
      rd_rt <= mem_rt[rd_addr];
      rd_tk <= mem_tk[rd_addr];
    end
    if (cmd.ld_write && slot_ok) begin
      mem_rt[ld_addr] <= req_r.load_runtime;
      mem_tk[ld_addr] <= ld_tk;
    end
    if (cmd.upd_write) begin
      mem_rt[wk_addr] <= new_rt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_vld     <= 1'b0;
      live_total <= '0;
    end else begin
      if (cmd.ld_read || cmd.walk_read) begin
        rd_vld <= valid[rd_addr];
      end
      if (cmd.ld_write && slot_ok) begin
        valid[ld_addr] <= 1'b1;
        live_total     <= live_total - TW'(eff_tk) + TW'(ld_tk);
      end
      // retiring clears the entry: runtime and tickets both read as zero
      if (cmd.upd_write && (new_rt == '0)) begin
        valid[wk_addr] <= 1'b0;
        live_total     <= live_total - TW'(eff_tk);
      end
    end
  end

  // walk and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      limit     <= '0;
      sum       <= '0;
      found_r   <= 1'b0;
      retired_r <= 1'b0;
      chosen_r  <= '0;
    end else begin
      if (cmd.accept) begin
        idx       <= '0;
        sum       <= '0;
        limit     <= (32'(task_count) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_count);
        found_r   <= 1'b0;
        retired_r <= 1'b0;
        chosen_r  <= '0;
      end
      if (cmd.walk_step) begin
        idx <= idx + CW'(1);
        sum <= sum_next;
      end
      if (cmd.upd_write) begin
        found_r   <= 1'b1;
        chosen_r  <= SLOT_W'(idx);
        retired_r <= (new_rt == '0);
      end
    end
  end

  assign result.found        = found_r;
  assign result.chosen_task  = chosen_r;
  assign result.task_retired = retired_r;
  assign result.all_done     = (live_total == '0);
  assign result.ticket_total = TICKET_W'(live_total);

endmodule

`default_nettype wire

// ===== rtl/lottery_scheduler_pick.sv =====
// Lottery scheduler pick, top level: controller plus datapath.
// Depends on lsp_pkg, lsp_ctrl and lsp_dp.
//
// Usage:
//   Request channel: drive req and raise start; the request is taken at the
//   clock edge where start is high and busy is low. op selects load or draw.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver must take it then, it cannot stall the block.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 quantum,
//   1 task_count) and cfg_data; cfg_ready is always high. Write only while
//   busy is low.
// Sequencing (one request at a time, busy while working):
//   load: states table read, table write, then result (done).
//   draw: the walk reads entries from slot 0 in turn, each through the
//   registered table read port and then evaluated; it ends after the pick
//   (then a runtime update and the result) or, when nothing is picked, after
//   all walked entries. A new request may be taken in the cycle after done.
// Reset (rst, synchronous): table reads as all zero (per-entry valid bits),
//   live total 0, quantum 1, task_count 0, controller idle.
`default_nettype none

module lottery_scheduler_pick import lsp_pkg::*; #(
  parameter int MAX_TASKS = DEFAULT_MAX_TASKS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire req_t                 req,
  output logic                      done,
  output rsp_t                      result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  lsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .start_op (req.op),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  lsp_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for lottery_scheduler_pick: load/draw requests, two config registers.
// Depends on lsp_pkg and the lottery_scheduler_pick RTL; predicts every result in-line.
`timescale 1ns / 100ps

module testbench;
  import lsp_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req_d = '0;
  logic                 done;
  rsp_t                 result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_QUANTUM;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  lottery_scheduler_pick u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req_d),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow of the task table and registers
  logic [RUNTIME_W-1:0] rt_tab [DEFAULT_MAX_TASKS];
  logic [TICKETS_W-1:0] tk_tab [DEFAULT_MAX_TASKS];
  int                   live_total = 0;
  logic [QUANTUM_W-1:0] quantum_m = QUANTUM_RST;
  logic [TCOUNT_W-1:0]  task_count_m = '0;

  req_t request_q [$];
  rsp_t outcome_q [$];

  int errors = 0;
  int n_loads = 0, n_draws = 0, n_picks = 0, n_retired = 0, n_misses = 0;
  int n_all_done = 0, n_settings = 0;
  int burst_left = 8, gap_left = 0;
  logic drain_mode = 1'b0;

  function automatic rsp_t lottery_step(req_t r);
    rsp_t                 o;
    int                   lim;
    int                   sum;
    logic [TICKETS_W-1:0] tk;
    logic                 hit;
    o = '0;
    hit = 1'b0;
    if (r.op == OP_LOAD) begin
      n_loads++;
      tk = (r.load_runtime == '0) ? '0 : r.load_tickets;
      live_total = live_total - int'(tk_tab[r.task_slot]) + int'(tk);
      rt_tab[r.task_slot] = r.load_runtime;
      tk_tab[r.task_slot] = tk;
    end else begin
      n_draws++;
      lim = (task_count_m > DEFAULT_MAX_TASKS) ? DEFAULT_MAX_TASKS : int'(task_count_m);
      sum = 0;
      for (int i = 0; i < lim && !hit; i++) begin
        sum += int'(tk_tab[i]);
        if (int'(r.drawn_ticket) <= sum && rt_tab[i] != '0) begin
          hit = 1'b1;
          o.found = 1'b1;
          o.chosen_task = 4'(i);
          rt_tab[i] = (rt_tab[i] > quantum_m) ? rt_tab[i] - quantum_m : '0;
          if (rt_tab[i] == '0) begin
            live_total -= int'(tk_tab[i]);
            tk_tab[i] = '0;
            o.task_retired = 1'b1;
            n_retired++;
          end
        end
      end
      if (hit) n_picks++;
      else n_misses++;
    end
    o.all_done = (live_total == 0);
    o.ticket_total = TICKET_W'(live_total);
    if (o.all_done) n_all_done++;
    return o;
  endfunction

  // register shadow follows the write channel
  always @(posedge clk) begin
    if (rst) begin
      quantum_m <= QUANTUM_RST;
      task_count_m <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUANTUM:    quantum_m <= cfg_data;
        CFG_TASK_COUNT: task_count_m <= cfg_data[TCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // driver: bursts of requests from request_q with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      for (int i = 0; i < DEFAULT_MAX_TASKS; i++) begin
        rt_tab[i] = '0;
        tk_tab[i] = '0;
      end
      live_total = 0;
    end else begin
      if (start && !busy) begin
        outcome_q.insert(outcome_q.size(), lottery_step(req_d));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if ($urandom_range(0, 79) == 0) drain_mode = 1'b1;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (drain_mode && outcome_q.size() != 0) begin
          start <= 1'b0;
        end else if (request_q.size() > 0) begin
          drain_mode = 1'b0;
          req_d <= request_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: one result per done strobe, checked against the oldest outcome
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result %p", $realtime, result);
      end else begin
        want = outcome_q.pop_front();
        if (result.found !== want.found || result.chosen_task !== want.chosen_task ||
            result.task_retired !== want.task_retired || result.all_done !== want.all_done ||
            result.ticket_total !== want.ticket_total) begin
          errors++;
          if (errors <= 10) begin
            $display("[%0t] mismatch: exp found=%0b task=%0d ret=%0b done=%0b total=%0d",
                     $realtime, want.found, want.chosen_task, want.task_retired,
                     want.all_done, want.ticket_total);
            $display("           got found=%0b task=%0d ret=%0b done=%0b total=%0d",
                     result.found, result.chosen_task, result.task_retired,
                     result.all_done, result.ticket_total);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait until no request is queued or in flight, then a few spare cycles
  task automatic settle();
    while (request_q.size() != 0 || start || busy || outcome_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_regs(input logic [QUANTUM_W-1:0] q, input logic [TCOUNT_W-1:0] tc);
    settle();
    write_reg(CFG_QUANTUM, q);
    write_reg(CFG_TASK_COUNT, CFG_DAT_W'(tc));
    n_settings++;
  endtask

  task automatic push_req(input logic op, input int slot, input int rt, input int tk,
                          input int ticket);
    req_t r;
    r.op = op;
    r.task_slot = SLOT_W'(slot);
    r.load_runtime = RUNTIME_W'(rt);
    r.load_tickets = TICKETS_W'(tk);
    r.drawn_ticket = TICKET_W'(ticket);
    request_q.insert(request_q.size(), r);
  endtask

  // generated a couple of requests ahead so draws can aim at the live total
  task automatic run_random(input int count);
    req_t r;
    int   pick;
    for (int k = 0; k < count; k++) begin
      while (request_q.size() >= 2) @(posedge clk);
      r.op = ($urandom_range(0, 99) < 40) ? OP_LOAD : OP_DRAW;
      r.task_slot = SLOT_W'($urandom_range(0, 15));
      r.load_runtime = RUNTIME_W'($urandom);
      r.load_tickets = TICKETS_W'($urandom);
      r.drawn_ticket = TICKET_W'($urandom);
      pick = $urandom_range(0, 99);
      if (r.op == OP_LOAD) begin
        if (pick < 8) r.load_runtime = '0;
        else if (pick < 65) r.load_runtime = RUNTIME_W'($urandom_range(1, 8));
        else if (pick < 85) r.load_runtime = RUNTIME_W'($urandom_range(9, 400));
        else if (pick < 90) r.load_runtime = '1;
        if ($urandom_range(0, 9) == 0) r.load_tickets = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        if (pick < 70) r.drawn_ticket = TICKET_W'($urandom_range(1, live_total + 2));
        else if (pick < 80) r.drawn_ticket = '0;
      end
      request_q.insert(request_q.size(), r);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_regs(16'd1, 5'd16);
    push_req(OP_LOAD, 0, 0, 1023, 0);      // zero runtime drops the tickets
    push_req(OP_DRAW, 0, 0, 0, 0);         // empty table, nothing picked
    push_req(OP_LOAD, 0, 3, 0, 0);         // live task holding no tickets
    push_req(OP_DRAW, 0, 0, 0, 0);         // ticket zero takes it anyway
    push_req(OP_LOAD, 15, 65535, 1023, 16383);
    push_req(OP_LOAD, 1, 1, 1, 0);
    push_req(OP_DRAW, 0, 0, 0, 1);         // slot 1, retires
    push_req(OP_DRAW, 0, 0, 0, 16383);     // beyond the sum
    push_req(OP_DRAW, 0, 0, 0, 1023);      // top slot
    push_req(OP_LOAD, 7, 2, 512, 0);
    push_req(OP_DRAW, 0, 0, 0, 512);
    push_req(OP_DRAW, 0, 0, 0, 513);
    push_req(OP_DRAW, 0, 0, 0, 1536);
    push_req(OP_DRAW, 0, 0, 0, 1537);
    push_req(OP_LOAD, 15, 65535, 0, 0);    // reload with fewer tickets
    push_req(OP_DRAW, 0, 0, 0, 8192);
    push_req(OP_LOAD, 7, 0, 5, 0);         // clears slot 7
    push_req(OP_DRAW, 0, 0, 0, 0);
    push_req(OP_DRAW, 0, 0, 0, 0);         // slot 0 retires, total now zero
    push_req(OP_DRAW, 0, 0, 0, 0);         // slot 15 still live with no tickets
    push_req(OP_LOAD, 3, 65535, 1023, 0);
    run_random(190);

    set_regs(16'hFFFF, 5'd16);
    run_random(190);
    set_regs(16'd0, 5'd31);                // runtime never drains
    run_random(190);
    set_regs(16'd5, 5'd8);
    run_random(190);
    set_regs(16'd2, 5'd0);                 // no entries walked
    run_random(90);
    set_regs(16'd300, 5'd17);
    run_random(190);
    set_regs(16'd1, 5'd1);
    run_random(110);
    set_regs(16'd3, 5'd16);
    run_random(200);

    settle();
    repeat (40) @(posedge clk);
    if (outcome_q.size() != 0) begin
      errors += outcome_q.size();
      $display("%0d results never arrived", outcome_q.size());
    end
    $display("covered %0d loads and %0d draws (%0d picks, %0d retirements, %0d misses)",
             n_loads, n_draws, n_picks, n_retired, n_misses);
    $display("over %0d register settings; %0d results with an empty ticket pool; %0d errors",
             n_settings, n_all_done, errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout waiting on the block");
    $display("testbench NOT OK");
    $finish;
  end

endmodule
